/* sv/dsct_pkg.sv */
// Package for the deficit/surplus carry table: sizes, item structs,
// table row layout and sequencer states. No dependencies.
`default_nettype none

package dsct_pkg;

    localparam int SUBJECT_COUNT = 64;
    localparam int SUBJ_W        = $clog2(SUBJECT_COUNT);
    localparam int DATA_W        = 64;

    typedef struct packed {
        logic [SUBJ_W-1:0]        subject;
        logic signed [DATA_W-1:0] net;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] credit_used;
        logic [DATA_W-1:0] debit_used;
        logic [DATA_W-1:0] deficit_added;
        logic [DATA_W-1:0] surplus_added;
        logic [DATA_W-1:0] new_deficit;
        logic [DATA_W-1:0] new_surplus;
        logic [DATA_W-1:0] new_lost_deficit;
        logic [DATA_W-1:0] new_lost_surplus;
        logic              saturated;
        logic              overflow_error;
    } t_out;

    // One table row: all four counters of a subject.
    typedef struct packed {
        logic [DATA_W-1:0] def;
        logic [DATA_W-1:0] sur;
        logic [DATA_W-1:0] ldef;
        logic [DATA_W-1:0] lsur;
    } t_row;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_USE1,
        ST_USE2,
        ST_GROW,
        ST_CLD,
        ST_ALD,
        ST_CLS,
        ST_ALS,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/deficit_surplus_carry_table.sv */
// Deficit/surplus carry table: one row memory with valid bits, a shared
// 64-bit add/subtract unit and its sequencer. Depends on dsct_pkg.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) carries a subject and a
//   signed net; output channel (o_out_valid/i_out_ready, o_out_item) returns
//   exactly one result item per input item, in order.
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data), always ready, writes
//   the carry cap. Write it only while the block is idle; the block never checks.
//   A single 64-bit adder/subtractor does every step (magnitude, consume,
//   grow, two clamps, two discard adds), one step per cycle; consuming a
//   smaller store takes one extra step, an add overflow cuts the sequence
//   short. o_in_ready is high only while the sequencer is idle, so a new
//   item is taken only once the previous one has left the sequencer.
//   The finished result sits in an output register, so the next item is
//   accepted while it waits; a further result waits in the last sequencer
//   step until the receiver takes the previous one.
//   Reset: table rows read as zero (per-row valid bits are cleared at once,
//   no clearing pass), the carry cap returns to all ones, no result pending.
`default_nettype none

module deficit_surplus_carry_table (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire dsct_pkg::t_in i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output dsct_pkg::t_out     o_out_item,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [dsct_pkg::DATA_W-1:0] i_cfg_data
);
    import dsct_pkg::*;

    t_state                r_state, n_state;
    logic [DATA_W-1:0]     r_carry_cap;
    logic [SUBJECT_COUNT-1:0] r_row_vld;
    t_row                  r_mem [SUBJECT_COUNT];
    t_row                  r_rd_row;
    logic                  r_rd_hit;

    logic [SUBJ_W-1:0]     r_subj;
    logic [DATA_W-1:0]     r_net;
    logic [DATA_W-1:0]     r_def, r_sur, r_ldef, r_lsur;
    logic [DATA_W-1:0]     r_rem, r_ex;
    logic [DATA_W-1:0]     r_credit, r_debit, r_dunits, r_sunits;
    logic                  r_sat, r_err;

    logic                  r_out_valid;
    t_out                  r_out;

    // shared unit
    logic [DATA_W-1:0]     u_a, u_b;
    logic                  u_sub;
    logic [DATA_W:0]       u_sum;
    logic                  u_carry, u_above;

    logic                  w_neg, w_acc, w_free, w_wr;
    logic [DATA_W-1:0]     w_other;

    assign w_neg   = r_net[DATA_W-1];
    assign w_other = w_neg ? r_def : r_sur;
    assign w_acc   = i_in_valid && o_in_ready;
    assign w_free  = !r_out_valid || i_out_ready;
    assign w_wr    = (r_state == ST_DONE) && w_free && !r_err;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign u_sum   = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {{DATA_W{1'b0}}, u_sub};
    assign u_carry = u_sum[DATA_W];
    // for a subtract: a strictly above b
    assign u_above = u_carry && (u_sum[DATA_W-1:0] != '0);

    always_comb begin
        n_state = r_state;
        u_a     = r_rem;
        u_b     = '0;
        u_sub   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) n_state = ST_MAG;
            end
            ST_MAG: begin
                // magnitude of the net; most negative value comes out as 2^63
                u_a     = w_neg ? '0 : r_net;
                u_b     = w_neg ? r_net : '0;
                u_sub   = w_neg;
                n_state = ST_USE1;
            end
            ST_USE1: begin
                u_a     = w_other;
                u_b     = r_rem;
                u_sub   = 1'b1;
                n_state = u_carry ? ST_GROW : ST_USE2;
            end
            ST_USE2: begin
                u_a     = r_rem;
                u_b     = w_other;
                u_sub   = 1'b1;
                n_state = ST_GROW;
            end
            ST_GROW: begin
                u_a     = w_neg ? r_sur : r_def;
                u_b     = r_rem;
                n_state = u_carry ? ST_DONE : ST_CLD;
            end
            ST_CLD: begin
                u_a     = r_def;
                u_b     = r_carry_cap;
                u_sub   = 1'b1;
                n_state = ST_ALD;
            end
            ST_ALD: begin
                u_a     = r_ldef;
                u_b     = r_ex;
                n_state = u_carry ? ST_DONE : ST_CLS;
            end
            ST_CLS: begin
                u_a     = r_sur;
                u_b     = r_carry_cap;
                u_sub   = 1'b1;
                n_state = ST_ALS;
            end
            ST_ALS: begin
                u_a     = r_lsur;
                u_b     = r_ex;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_carry_cap <= '1;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_carry_cap <= i_cfg_data;
            if (w_wr) r_row_vld[r_subj] <= 1'b1;
            if (r_state == ST_DONE && w_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // row memory
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_subj] <= '{def: r_def, sur: r_sur, ldef: r_ldef, lsur: r_lsur};
        if (w_acc) r_rd_row <= r_mem[i_in_item.subject];
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_subj   <= i_in_item.subject;
            r_net    <= unsigned'(i_in_item.net);
            r_rd_hit <= r_row_vld[i_in_item.subject];
        end
        unique case (r_state)
            ST_MAG: begin
                r_def    <= r_rd_hit ? r_rd_row.def  : '0;
                r_sur    <= r_rd_hit ? r_rd_row.sur  : '0;
                r_ldef   <= r_rd_hit ? r_rd_row.ldef : '0;
                r_lsur   <= r_rd_hit ? r_rd_row.lsur : '0;
                r_rem    <= u_sum[DATA_W-1:0];
                r_credit <= '0;
                r_debit  <= '0;
                r_dunits <= '0;
                r_sunits <= '0;
                r_sat    <= 1'b0;
                r_err    <= 1'b0;
            end
            ST_USE1: begin
                if (u_carry) begin
                    // store covers the whole net
                    if (w_neg) begin
                        r_debit <= r_rem;
                        r_def   <= u_sum[DATA_W-1:0];
                    end else begin
                        r_credit <= r_rem;
                        r_sur    <= u_sum[DATA_W-1:0];
                    end
                    r_rem <= '0;
                end else if (w_neg) begin
                    r_debit <= r_def;
                end else begin
                    r_credit <= r_sur;
                end
            end
            ST_USE2: begin
                r_rem <= u_sum[DATA_W-1:0];
                if (w_neg) r_def <= '0;
                else       r_sur <= '0;
            end
            ST_GROW: begin
                if (u_carry) begin
                    r_err <= 1'b1;
                end else if (w_neg) begin
                    r_sur    <= u_sum[DATA_W-1:0];
                    r_sunits <= r_rem;
                end else begin
                    r_def    <= u_sum[DATA_W-1:0];
                    r_dunits <= r_rem;
                end
            end
            ST_CLD, ST_CLS: begin
                if (u_above) begin
                    r_ex  <= u_sum[DATA_W-1:0];
                    r_sat <= 1'b1;
                    if (r_state == ST_CLD) r_def <= r_carry_cap;
                    else                   r_sur <= r_carry_cap;
                end else begin
                    r_ex <= '0;
                end
            end
            ST_ALD: begin
                if (u_carry) r_err  <= 1'b1;
                else         r_ldef <= u_sum[DATA_W-1:0];
            end
            ST_ALS: begin
                if (u_carry) r_err  <= 1'b1;
                else         r_lsur <= u_sum[DATA_W-1:0];
            end
            ST_IDLE, ST_DONE: begin
            end
            default: begin
            end
        endcase
        if (r_state == ST_DONE && w_free) begin
            if (r_err) begin
                r_out <= '{overflow_error: 1'b1, default: '0};
            end else begin
                r_out.credit_used      <= r_credit;
                r_out.debit_used       <= r_debit;
                r_out.deficit_added    <= r_dunits;
                r_out.surplus_added    <= r_sunits;
                r_out.new_deficit      <= r_def;
                r_out.new_surplus      <= r_sur;
                r_out.new_lost_deficit <= r_ldef;
                r_out.new_lost_surplus <= r_lsur;
                r_out.saturated        <= r_sat;
                r_out.overflow_error   <= 1'b0;
            end
        end
    end

    // error results carry nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow_error |->
            o_out_item.new_deficit == '0 && o_out_item.new_surplus == '0 &&
            o_out_item.saturated == 1'b0 && o_out_item.credit_used == '0)
        else $error("overflow result with non-zero fields");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.overflow_error |->
            o_out_item.new_deficit <= r_carry_cap && o_out_item.new_surplus <= r_carry_cap)
        else $error("carried counter above the carry cap");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.credit_used == '0 || o_out_item.debit_used == '0))
        else $error("credit and debit both applied");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !o_in_ready && !w_wr)
        else $error("sequencer not busy after accept");

endmodule

`default_nettype wire

/* dv/tb_deficit_surplus_carry_table.sv */
// Testbench for deficit_surplus_carry_table: directed and random update items
// checked against a per-subject carry ledger kept in a scoreboard class.
// Depends on dsct_pkg and the block's RTL.

module tb_deficit_surplus_carry_table;
    import dsct_pkg::*;

    class carry_ledger;
        logic [DATA_W-1:0] deficit_row [SUBJECT_COUNT];
        logic [DATA_W-1:0] surplus_row [SUBJECT_COUNT];
        logic [DATA_W-1:0] lost_deficit_row [SUBJECT_COUNT];
        logic [DATA_W-1:0] lost_surplus_row [SUBJECT_COUNT];
        logic [DATA_W-1:0] carry_cap;
        t_out              due_updates [$];
        int unsigned       errors;

        function new();
            for (int k = 0; k < SUBJECT_COUNT; k++) begin
                deficit_row[k]      = '0;
                surplus_row[k]      = '0;
                lost_deficit_row[k] = '0;
                lost_surplus_row[k] = '0;
            end
            carry_cap = '1;
            errors    = 0;
        endfunction

        function void set_carry_cap(logic [DATA_W-1:0] value);
            carry_cap = value;
        endfunction

        function int unsigned outstanding();
            return due_updates.size();
        endfunction

        // Works out the result of one accepted item and updates the ledger.
        function void note_item(t_in it);
            t_out              r;
            logic [DATA_W-1:0] d, s, ld, ls, rem, ex;
            logic [DATA_W:0]   sum;
            bit                ovf;
            r   = '0;
            ovf = 1'b0;
            d   = deficit_row[it.subject];
            s   = surplus_row[it.subject];
            ld  = lost_deficit_row[it.subject];
            ls  = lost_surplus_row[it.subject];
            if (!it.net[DATA_W-1]) begin
                rem = it.net;
                r.credit_used = (rem < s) ? rem : s;
                s   = s - r.credit_used;
                rem = rem - r.credit_used;
                r.deficit_added = rem;
                sum = {1'b0, d} + {1'b0, rem};
                ovf = sum[DATA_W];
                d   = sum[DATA_W-1:0];
            end else begin
                // magnitude of the most negative net is exactly 2^63 as unsigned
                rem = ~it.net + 64'd1;
                r.debit_used = (rem < d) ? rem : d;
                d   = d - r.debit_used;
                rem = rem - r.debit_used;
                r.surplus_added = rem;
                sum = {1'b0, s} + {1'b0, rem};
                ovf = sum[DATA_W];
                s   = sum[DATA_W-1:0];
            end
            if (!ovf && d > carry_cap) begin
                ex  = d - carry_cap;
                sum = {1'b0, ld} + {1'b0, ex};
                ovf = sum[DATA_W];
                ld  = sum[DATA_W-1:0];
                d   = carry_cap;
                r.saturated = 1'b1;
            end
            if (!ovf && s > carry_cap) begin
                ex  = s - carry_cap;
                sum = {1'b0, ls} + {1'b0, ex};
                ovf = sum[DATA_W];
                ls  = sum[DATA_W-1:0];
                s   = carry_cap;
                r.saturated = 1'b1;
            end
            if (ovf) begin
                // entry untouched, every other field zero
                r = '0;
                r.overflow_error = 1'b1;
            end else begin
                deficit_row[it.subject]      = d;
                surplus_row[it.subject]      = s;
                lost_deficit_row[it.subject] = ld;
                lost_surplus_row[it.subject] = ls;
                r.new_deficit      = d;
                r.new_surplus      = s;
                r.new_lost_deficit = ld;
                r.new_lost_surplus = ls;
            end
            due_updates.push_back(r);
        endfunction

        function void compare_field(string field, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (due_updates.size() == 0) begin
                errors++;
                $display("%0t: result with no item outstanding, expected none got %h",
                         $time, got);
                return;
            end
            want = due_updates.pop_front();
            compare_field("credit_used", want.credit_used, got.credit_used);
            compare_field("debit_used", want.debit_used, got.debit_used);
            compare_field("deficit_added", want.deficit_added, got.deficit_added);
            compare_field("surplus_added", want.surplus_added, got.surplus_added);
            compare_field("new_deficit", want.new_deficit, got.new_deficit);
            compare_field("new_surplus", want.new_surplus, got.new_surplus);
            compare_field("new_lost_deficit", want.new_lost_deficit, got.new_lost_deficit);
            compare_field("new_lost_surplus", want.new_lost_surplus, got.new_lost_surplus);
            compare_field("saturated", {63'd0, want.saturated}, {63'd0, got.saturated});
            compare_field("overflow_error", {63'd0, want.overflow_error},
                          {63'd0, got.overflow_error});
        endfunction
    endclass

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] NET_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] NET_MIN  = 64'h8000_0000_0000_0000;
    localparam int unsigned QUIET_LIMIT = 4000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_in               in_item = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic              in_ready;
    logic              out_valid;
    logic              cfg_ready;
    t_out              out_item;

    int unsigned       src_idle_pct = 0;
    int unsigned       snk_stall_pct = 0;
    int unsigned       quiet_cycles = 0;
    carry_ledger       board;

    deficit_surplus_carry_table uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_result(out_item);
        end
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [SUBJ_W-1:0] subj, input logic [DATA_W-1:0] raw);
        t_in it;
        it.subject = subj;
        it.net     = raw;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(it);
    endtask

    task automatic write_carry_cap(input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_carry_cap(value);
    endtask

    // Drains the block: every expected result back before the next setting.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    task automatic random_run(input int unsigned count);
        logic [SUBJ_W-1:0] subj;
        logic [DATA_W-1:0] raw;
        int unsigned       pick;
        for (int n = 0; n < count; n++) begin
            // a few busy subjects so counters build up towards the limits
            pick = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(63);
            subj = pick[SUBJ_W-1:0];
            case ($urandom_range(9))
                0: raw = {32'd0, $urandom_range(15)};
                1: begin
                    raw = {32'd0, $urandom_range(16, 1)};
                    raw = -raw;
                end
                2: raw = NET_MAX - {32'd0, $urandom_range(255)};
                3: raw = NET_MIN + {32'd0, $urandom_range(255)};
                4: begin
                    case ($urandom_range(3))
                        0: raw = '0;
                        1: raw = NET_MAX;
                        2: raw = NET_MIN;
                        default: raw = ALL_ONES;
                    endcase
                end
                5: begin
                    raw = {32'd0, $urandom_range(3000)};
                    if ($urandom_range(1) == 1) raw = -raw;
                end
                6: begin
                    raw = {1'b0, 31'($urandom), $urandom} >> $urandom_range(63);
                    if ($urandom_range(1) == 1) raw = -raw;
                end
                default: raw = {$urandom, $urandom};
            endcase
            send_item(subj, raw);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] cap;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no clamping: consume in both directions, then the add overflows
        write_carry_cap(ALL_ONES);
        send_item(6'd0, 64'd0);
        send_item(6'd0, 64'd5);
        send_item(6'd0, -64'd3);
        send_item(6'd0, -64'd10);
        send_item(6'd0, 64'd3);
        send_item(6'd0, 64'd20);
        send_item(6'd63, NET_MAX);
        send_item(6'd63, NET_MAX);
        send_item(6'd63, 64'd1);
        send_item(6'd63, 64'd1);
        send_item(6'd1, NET_MIN);
        send_item(6'd1, NET_MIN);
        send_item(6'd1, ALL_ONES);
        settle();

        // zero cap: everything discarded, discarded totals overflow
        write_carry_cap('0);
        send_item(6'd0, 64'd0);
        send_item(6'd2, 64'd100);
        send_item(6'd2, -64'd7);
        send_item(6'd3, NET_MAX);
        send_item(6'd3, NET_MAX);
        send_item(6'd3, NET_MAX);
        send_item(6'd4, NET_MIN);
        send_item(6'd4, NET_MIN);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    cap = ALL_ONES;
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    cap = {32'd0, $urandom_range(5000, 1)};
                    src_idle_pct = 82;
                    snk_stall_pct = 0;
                end
                2: begin
                    cap = '0;
                    src_idle_pct = 0;
                    snk_stall_pct = 82;
                end
                3: begin
                    cap = {$urandom, $urandom};
                    src_idle_pct = 38;
                    snk_stall_pct = 38;
                end
                4: begin
                    cap = NET_MIN;
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                default: begin
                    cap = ALL_ONES;
                    src_idle_pct = 38;
                    snk_stall_pct = 82;
                end
            endcase
            write_carry_cap(cap);
            random_run(330);
            settle();
        end

        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
